// ----- rtl/core/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants for the sorted timer queue: sizes, operation
// and status codes, and the result bundle of the wraparound time compare.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
  localparam int FIRE_W = $clog2(MAX_RESULTS + 1);

  localparam int ID_W   = 8;
  localparam int TIME_W = 32;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_PROCESS = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [TIME_W-1:0] diff;
    logic              earlier;
    logic              zero;
  } cmp_t;

endpackage

// ----- rtl/core/stq_time_cmp.sv -----
// ----------------------------------------------------------------------------
// stq_time_cmp
// Wraparound time compare: a - b modulo 2^32, with the sign bit taken as
// "a is before b" and a flag for equal times.
// ----------------------------------------------------------------------------
module stq_time_cmp (
  input  logic [stq_pkg::TIME_W-1:0] a,
  input  logic [stq_pkg::TIME_W-1:0] b,
  output stq_pkg::cmp_t              res
);
  import stq_pkg::*;

  logic [TIME_W-1:0] diff;

  assign diff        = a - b;
  assign res.diff    = diff;
  assign res.earlier = diff[TIME_W-1];
  assign res.zero    = (diff == '0);

endmodule

// ----- rtl/core/sorted_timer_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit
// Timer queue sorted by wraparound due time, walked one slot per cycle.
// ----------------------------------------------------------------------------
// Operation: add and remove scan every queued slot, then, when the queue
// changes, shift the tail one slot per cycle; an add then writes the new
// timer into its slot before the result is valid. Process pops each due
// head and shifts the rest down, one result per fired timer. One item is
// in flight at a time; in_stall stays high until its last result is
// transferred. Reset empties the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_timer_queue_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  stq_pkg::op_t                operation,
  input  logic [stq_pkg::ID_W-1:0]    timer_id,
  input  logic [stq_pkg::TIME_W-1:0]  due_time,
  input  logic [stq_pkg::TIME_W-1:0]  now,
  output logic                        out_valid,
  input  logic                        out_stall,
  output stq_pkg::status_t            status,
  output logic                        fired_valid,
  output logic [stq_pkg::ID_W-1:0]    fired_id,
  output logic signed [stq_pkg::TIME_W-1:0] time_until_next,
  output logic                        last
);
  import stq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_INSERT,
    S_CHECK,
    S_FINISH,
    S_RESP
  } state_t;

  state_t state;

  // slot memory
  logic [ID_W-1:0]   mem_ids [TIMER_SLOTS];
  logic [TIME_W-1:0] mem_due [TIMER_SLOTS];
  logic [ID_W-1:0]   rd_id;
  logic [TIME_W-1:0] rd_due;
  logic              rd_en;
  logic [IDX_W-1:0]  raddr;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [ID_W-1:0]   wid;
  logic [TIME_W-1:0] wdue;

  // head copy, kept in step with slot 0
  logic [ID_W-1:0]   head_id;
  logic [TIME_W-1:0] head_due;

  logic [CNT_W-1:0]  count;
  op_t               op_r;
  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] due_r;
  logic [TIME_W-1:0] now_r;
  status_t           st_r;

  logic              found;
  logic [IDX_W-1:0]  pos_r;
  logic              ins_found;
  logic [CNT_W-1:0]  ins_r;
  logic [CNT_W-1:0]  scan_cnt;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;

  logic              sh_up;
  logic [CNT_W-1:0]  sh_src;
  logic [CNT_W-1:0]  sh_rem;
  logic              sh_pend;
  logic [IDX_W-1:0]  sh_dst;

  logic              fired_r;
  logic [ID_W-1:0]   fire_id_r;
  logic [FIRE_W-1:0] fire_n;

  logic [TIME_W-1:0] cmp_a;
  logic [TIME_W-1:0] cmp_b;
  cmp_t              cmp;
  logic              head_due_now;
  logic [TIME_W-1:0] tun;

  assign in_stall = (state != S_IDLE);

  // shared compare: new due vs slot during scan, head vs now otherwise
  assign cmp_a = (state == S_SCAN) ? due_r  : head_due;
  assign cmp_b = (state == S_SCAN) ? rd_due : now_r;

  stq_time_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  assign head_due_now = cmp.zero || cmp.earlier;
  assign tun = (count == '0) ? '1 : (cmp.earlier ? '0 : cmp.diff);

  assign rd_en = ((state == S_SCAN) && (scan_cnt != count)) ||
                 ((state == S_SHIFT) && (sh_rem != '0));
  assign raddr = (state == S_SHIFT) ? sh_src[IDX_W-1:0] : scan_cnt[IDX_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = sh_dst;
    wid   = rd_id;
    wdue  = rd_due;
    priority if (state == S_INSERT) begin
      we    = 1'b1;
      waddr = ins_r[IDX_W-1:0];
      wid   = id_r;
      wdue  = due_r;
    end else if ((state == S_SHIFT) && sh_pend) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_ids[waddr] <= wid;
      mem_due[waddr] <= wdue;
    end
    if (rd_en) begin
      rd_id  <= mem_ids[raddr];
      rd_due <= mem_due[raddr];
    end
    if (we && (waddr == '0)) begin
      head_id  <= wid;
      head_due <= wdue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      sh_pend   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= operation;
            id_r      <= timer_id;
            due_r     <= due_time;
            now_r     <= now;
            st_r      <= ST_OK;
            fired_r   <= 1'b0;
            fire_n    <= '0;
            found     <= 1'b0;
            ins_found <= 1'b0;
            ins_r     <= count;
            scan_cnt  <= '0;
            pend      <= 1'b0;
            unique case (operation)
              OP_ADD, OP_REMOVE: state <= S_SCAN;
              OP_PROCESS:        state <= S_CHECK;
              default:           state <= S_FINISH;
            endcase
          end
        end

        S_SCAN: begin
          if (scan_cnt != count) begin
            scan_cnt <= scan_cnt + 1'b1;
            pend     <= 1'b1;
            pend_idx <= scan_cnt[IDX_W-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if ((rd_id == id_r) && !found) begin
              found <= 1'b1;
              pos_r <= pend_idx;
            end
            // first slot due strictly after the new timer
            if ((op_r == OP_ADD) && !ins_found && cmp.earlier) begin
              ins_found <= 1'b1;
              ins_r     <= CNT_W'(pend_idx);
            end
          end
          if ((scan_cnt == count) && !pend) begin
            sh_pend <= 1'b0;
            if (op_r == OP_ADD) begin
              priority if (found) begin
                st_r  <= ST_PRESENT;
                state <= S_FINISH;
              end else if (count == CNT_W'(TIMER_SLOTS)) begin
                st_r  <= ST_FULL;
                state <= S_FINISH;
              end else begin
                sh_up  <= 1'b1;
                sh_src <= count - 1'b1;
                sh_rem <= count - ins_r;
                state  <= S_SHIFT;
              end
            end else begin
              if (found) begin
                sh_up  <= 1'b0;
                sh_src <= CNT_W'(pos_r) + 1'b1;
                sh_rem <= count - CNT_W'(pos_r) - 1'b1;
                state  <= S_SHIFT;
              end else begin
                st_r  <= ST_NOT_FOUND;
                state <= S_FINISH;
              end
            end
          end
        end

        S_SHIFT: begin
          if (sh_rem != '0) begin
            sh_pend <= 1'b1;
            sh_dst  <= sh_up ? IDX_W'(sh_src + 1'b1) : IDX_W'(sh_src - 1'b1);
            sh_src  <= sh_up ? (sh_src - 1'b1) : (sh_src + 1'b1);
            sh_rem  <= sh_rem - 1'b1;
          end else begin
            sh_pend <= 1'b0;
            if (!sh_pend) begin
              if (sh_up) begin
                state <= S_INSERT;
              end else begin
                count <= count - 1'b1;
                state <= S_FINISH;
              end
            end
          end
        end

        S_INSERT: begin
          count <= count + 1'b1;
          state <= S_FINISH;
        end

        S_CHECK: begin
          if ((count != '0) && head_due_now && (fire_n != FIRE_W'(MAX_RESULTS))) begin
            // pop the head: shift everything down by one
            fired_r   <= 1'b1;
            fire_id_r <= head_id;
            fire_n    <= fire_n + 1'b1;
            sh_up     <= 1'b0;
            sh_src    <= CNT_W'(1);
            sh_rem    <= count - 1'b1;
            sh_pend   <= 1'b0;
            state     <= S_SHIFT;
          end else begin
            fired_r <= 1'b0;
            state   <= S_FINISH;
          end
        end

        S_FINISH: begin
          out_valid       <= 1'b1;
          status          <= st_r;
          fired_valid     <= fired_r;
          fired_id        <= fired_r ? fire_id_r : '0;
          time_until_next <= tun;
          if (fired_r) begin
            last <= (count == '0) || (fire_n == FIRE_W'(MAX_RESULTS)) || !head_due_now;
          end else begin
            last <= 1'b1;
          end
          state <= S_RESP;
        end

        S_RESP: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if ((op_r == OP_PROCESS) && fired_r && !last) begin
              state <= S_CHECK;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TIMER_SLOTS))
    else $error("queue count above slot count");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |-> (count < CNT_W'(TIMER_SLOTS)))
    else $error("insert into a full queue");

  a_nofire_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !fired_valid) |-> (last && (fired_id == '0)))
    else $error("result without fired timer must be last with zero id");

  a_empty_tun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (count == '0)) |-> (time_until_next == '1))
    else $error("empty queue must report minus one");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> (!out_valid && (state == S_IDLE)))
    else $error("results continue after last");

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives add, remove and process requests into the sorted timer queue and
// checks every result against a shadow queue kept in the bench, using random
// gaps on the request side and random holds on the result side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stq_pkg::*;

  typedef struct packed {
    status_t           status;
    logic              fired_valid;
    logic [ID_W-1:0]   fired_id;
    logic [TIME_W-1:0] wait_ticks;
    logic              last;
  } timer_result_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  op_t                      operation = OP_NONE;
  logic [ID_W-1:0]          timer_id = '0;
  logic [TIME_W-1:0]        due_time = '0;
  logic [TIME_W-1:0]        now = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  status_t                  status;
  logic                     fired_valid;
  logic [ID_W-1:0]          fired_id;
  logic signed [TIME_W-1:0] time_until_next;
  logic                     last;

  // shadow copy of the queue, in due order
  logic [ID_W-1:0]   shadow_ids [TIMER_SLOTS];
  logic [TIME_W-1:0] shadow_due [TIMER_SLOTS];
  int                shadow_len = 0;

  timer_result_t awaited_results[$];
  int unsigned   mismatch_count = 0;

  bit                tx_idle = 1'b1;
  bit                rx_idle = 1'b1;
  int unsigned       rx_hold_cycles = 0;
  logic [TIME_W-1:0] timeline_now = '0;

  sorted_timer_queue_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .timer_id        (timer_id),
    .due_time        (due_time),
    .now             (now),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .fired_valid     (fired_valid),
    .fired_id        (fired_id),
    .time_until_next (time_until_next),
    .last            (last)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [TIME_W-1:0] head_wait(logic [TIME_W-1:0] t_now);
    logic [TIME_W-1:0] d;
    if (shadow_len == 0) return '1;
    d = shadow_due[0] - t_now;
    return d[TIME_W-1] ? '0 : d;
  endfunction

  function automatic int locate_timer(logic [ID_W-1:0] id);
    for (int i = 0; i < shadow_len; i++)
      if (shadow_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < shadow_len; i++) begin
      shadow_ids[i] = shadow_ids[i + 1];
      shadow_due[i] = shadow_due[i + 1];
    end
    shadow_len--;
  endfunction

  // Apply one request to the shadow queue and queue up the results it causes.
  function automatic void model_timer_op(op_t op, logic [ID_W-1:0] id,
                                         logic [TIME_W-1:0] due,
                                         logic [TIME_W-1:0] t_now);
    status_t           st;
    int                pos;
    int                ins;
    int                fired;
    logic [TIME_W-1:0] diff;
    logic [ID_W-1:0]   fid;
    st = ST_OK;
    fired = 0;
    case (op)
      OP_ADD: begin
        if (locate_timer(id) >= 0) begin
          st = ST_PRESENT;
        end else if (shadow_len >= TIMER_SLOTS) begin
          st = ST_FULL;
        end else begin
          // new timer goes after every entry due at or before it
          ins = 0;
          while (ins < shadow_len) begin
            diff = due - shadow_due[ins];
            if (diff[TIME_W-1]) break;
            ins++;
          end
          for (int i = shadow_len; i > ins; i--) begin
            shadow_ids[i] = shadow_ids[i - 1];
            shadow_due[i] = shadow_due[i - 1];
          end
          shadow_ids[ins] = id;
          shadow_due[ins] = due;
          shadow_len++;
        end
      end
      OP_REMOVE: begin
        pos = locate_timer(id);
        if (pos >= 0) drop_slot(pos);
        else st = ST_NOT_FOUND;
      end
      OP_PROCESS: begin
        while (fired < MAX_RESULTS && shadow_len > 0) begin
          diff = shadow_due[0] - t_now;
          if (diff != '0 && !diff[TIME_W-1]) break;
          fid = shadow_ids[0];
          drop_slot(0);
          awaited_results.push_back(timer_result_t'{ST_OK, 1'b1, fid,
                                                    head_wait(t_now), 1'b0});
          fired++;
        end
      end
      default: ;
    endcase
    if (fired == 0)
      awaited_results.push_back(timer_result_t'{st, 1'b0, '0, head_wait(t_now), 1'b1});
    else
      awaited_results[awaited_results.size() - 1].last = 1'b1;
  endfunction

  // Present one request and hold it until the transfer, then predict it.
  task automatic offer_timer_op(op_t op, logic [ID_W-1:0] id,
                                logic [TIME_W-1:0] due, logic [TIME_W-1:0] t_now);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation <= op;
    timer_id  <= id;
    due_time  <= due;
    now       <= t_now;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    model_timer_op(op, id, due, t_now);
  endtask

  // Well-formed traffic: due times near a moving clock, a small id pool.
  task automatic run_timeline(int unsigned count);
    int unsigned     pick;
    logic [ID_W-1:0] id;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      id = ID_W'($urandom_range(0, 19));
      if (pick < 42) begin
        offer_timer_op(OP_ADD, id, timeline_now + $urandom_range(0, 600) - 32'd100,
                       timeline_now);
      end else if (pick < 47) begin
        // straddle the half-range point of the wraparound compare
        offer_timer_op(OP_ADD, id, timeline_now + 32'h7FFF_FF00 + $urandom_range(0, 511),
                       timeline_now);
      end else if (pick < 65) begin
        offer_timer_op(OP_REMOVE, id, $urandom, timeline_now);
      end else if (pick < 96) begin
        timeline_now += $urandom_range(0, 200);
        offer_timer_op(OP_PROCESS, ID_W'($urandom), $urandom, timeline_now);
      end else begin
        offer_timer_op(OP_NONE, ID_W'($urandom), $urandom, timeline_now);
      end
    end
  endtask

  task automatic test_directed_cases();
    offer_timer_op(OP_PROCESS, 8'h00, 32'h0000_0000, 32'h0000_0000);
    offer_timer_op(OP_REMOVE, 8'h07, 32'h0000_0000, 32'h0000_0000);
    offer_timer_op(OP_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_timer_op(OP_ADD, 8'h00, 32'h0000_0000, 32'h8000_0001);
    // wraps to just before zero, so it takes the head
    offer_timer_op(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
    // duplicate id sitting behind the insertion point
    offer_timer_op(OP_ADD, 8'h00, 32'hFFFF_FFF0, 32'h0000_0000);
    // equal due time lands after the existing entry
    offer_timer_op(OP_ADD, 8'h5A, 32'h0000_0000, 32'h0000_0000);
    offer_timer_op(OP_PROCESS, 8'h00, 32'h0000_0000, 32'hFFFF_FF00);
    offer_timer_op(OP_REMOVE, 8'h5A, 32'h0000_0000, 32'hFFFF_FF00);
    for (int k = 1; k <= 14; k++)
      offer_timer_op(OP_ADD, ID_W'(8'h10 + k), 32'(7 * k), 32'h0000_0000);
    offer_timer_op(OP_ADD, 8'hA5, 32'h0000_0100, 32'h0000_0000);
    // present check wins over full
    offer_timer_op(OP_ADD, 8'hFF, 32'h0000_0100, 32'h0000_0000);
    offer_timer_op(OP_PROCESS, 8'h00, 32'h0000_0000, 32'd1000);
  endtask

  task automatic test_random_timeline();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    timeline_now = $urandom;
    run_timeline(200);
  endtask

  task automatic test_receiver_holdoff();
    tx_idle = 1'b0;
    rx_hold_cycles = 400;
    run_timeline(30);
    tx_idle = 1'b1;
  endtask

  task automatic test_wrap_crossing();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    timeline_now = 32'hFFFF_F000;
    run_timeline(120);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_field_noise();
    repeat (60)
      offer_timer_op(op_t'($urandom_range(0, 3)), ID_W'($urandom), $urandom, $urandom);
  endtask

  // result side: hold for a drawn number of cycles, then take one transfer
  always begin : rx_side
    int unsigned pause;
    @(negedge clk);
    if (rx_hold_cycles > 0) begin
      pause = rx_hold_cycles;
      rx_hold_cycles = 0;
    end else begin
      pause = rx_idle ? $urandom_range(0, 6) : 0;
    end
    if (pause > 0) begin
      out_stall <= 1'b1;
      repeat (pause) @(negedge clk);
    end
    out_stall <= 1'b0;
    do @(posedge clk); while (!out_valid);
  end

  always @(posedge clk) begin : result_check
    timer_result_t got;
    timer_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {status, fired_valid, fired_id, time_until_next, last};
      if (awaited_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: status %0d fired %0b id %0d wait %0d last %0b",
                   got.status, got.fired_valid, got.fired_id, got.wait_ticks, got.last);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10)
            $display("mismatch: got status %0d fired %0b id %0d wait %0d last %0b, ",
                     got.status, got.fired_valid, got.fired_id, got.wait_ticks, got.last,
                     "want status %0d fired %0b id %0d wait %0d last %0b",
                     want.status, want.fired_valid, want.fired_id, want.wait_ticks,
                     want.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_timeline();
    test_receiver_holdoff();
    test_wrap_crossing();
    test_field_noise();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
